[design/assert_macros.svh]
// assertion macros used by the top-level design file
// compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VNS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define VNS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define VNS_ASSERT_IMP(label, clk, rst, a, b)
`define VNS_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[design/vns_pkg.sv]
// package for the vector normalize and scale block
// widths and the item type passed from front to back; no dependencies
package vns_pkg;
  localparam int CB = 32;           // component width
  localparam int SW = 2 * CB + 2;   // sum of squares
  localparam int RW = 4 * CB;       // squared scaled magnitude / remainder
  localparam int PW = 3 * CB + 2;   // running q * s
  localparam int DW = 4 * CB + 3;   // trial term width

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [SW-1:0]         s;
    logic [2:0][RW-1:0]    r;
  } item_t;
endpackage

[design/vns_front.sv]
// front pipeline: magnitudes, signs, zero check, sum of squares and
// squared scaled magnitudes; depends on vns_pkg
module vns_front import vns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CB-1:0] in_x,
  input  logic [CB-1:0] in_y,
  input  logic [CB-1:0] in_z,
  input  logic [CB-1:0] target_length,
  output logic          push_valid,
  input  logic          push_ready,
  output item_t         push_data
);
  logic v1, v2, v3, v4;
  logic adv;
  logic [2:0][CB-1:0] mag1;
  logic [CB-1:0] mt1;
  logic [2:0] nv1;
  logic nt1;
  logic [2:0][2*CB-1:0] sq2, m2;
  logic [2:0] neg2, neg3;
  logic zero2, zero3;
  logic [SW-1:0] s3;
  logic [2:0][2*CB-1:0] ph3, pm3, pl3;
  logic [CB-1:0] src [3];

  assign adv      = !v4 || push_ready;
  assign in_ready = adv;
  assign src[0] = in_x;
  assign src[1] = in_y;
  assign src[2] = in_z;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // stage 1: sign and magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nv1[i]  <= src[i][CB-1];
        mag1[i] <= src[i][CB-1] ? (~src[i] + CB'(1)) : src[i];
      end
      nt1 <= target_length[CB-1];
      mt1 <= target_length[CB-1] ? (~target_length + CB'(1)) : target_length;
    end
  end

  // stage 2: squares and scaled magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i]  <= (2*CB)'(mag1[i]) * (2*CB)'(mag1[i]);
        m2[i]   <= (2*CB)'(mag1[i]) * (2*CB)'(mt1);
        neg2[i] <= nv1[i] ^ nt1;
      end
      zero2 <= (mag1 == '0);
    end
  end

  // stage 3: sum of squares, partial products of the squared scaled magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
      for (int i = 0; i < 3; i++) begin
        ph3[i] <= (2*CB)'(m2[i][2*CB-1:CB]) * (2*CB)'(m2[i][2*CB-1:CB]);
        pm3[i] <= (2*CB)'(m2[i][2*CB-1:CB]) * (2*CB)'(m2[i][CB-1:0]);
        pl3[i] <= (2*CB)'(m2[i][CB-1:0]) * (2*CB)'(m2[i][CB-1:0]);
      end
      neg3  <= neg2;
      zero3 <= zero2;
    end
  end

  // stage 4: combine partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        push_data.r[i] <= (RW'(ph3[i]) << (2*CB)) + (RW'(pm3[i]) << (CB+1))
                          + RW'(pl3[i]);
      end
      push_data.s    <= s3;
      push_data.neg  <= neg3;
      push_data.zero <= zero3;
    end
  end

  assign push_valid = v4;
endmodule

[design/vns_queue.sv]
// two-entry queue between front and back pipelines
// depends on vns_pkg for the item type
module vns_queue import vns_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);
  item_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[design/vns_back.sv]
// back pipeline: one quotient bit per stage for each component, then
// sign and saturation into the output register; depends on vns_pkg
module vns_back import vns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  item_t         pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB-1:0] out_x,
  output logic [CB-1:0] out_y,
  output logic [CB-1:0] out_z,
  output logic          zero_input,
  output logic          clipped
);
  logic adv;
  logic vld [0:CB];
  logic zero_st [0:CB];
  logic [2:0] neg_st [0:CB];
  logic [SW-1:0] s_st [0:CB];
  logic [2:0][RW-1:0] r_st [0:CB];
  logic [2:0][PW-1:0] p_st [0:CB];
  logic [2:0][CB-1:0] q_st [0:CB];
  logic [2:0][CB-1:0] res;
  logic [2:0] clip;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_st[0] <= pop_data.zero;
      neg_st[0]  <= pop_data.neg;
      s_st[0]    <= pop_data.s;
      r_st[0]    <= pop_data.r;
      p_st[0]    <= '0;
      q_st[0]    <= '0;
    end
  end

  // one stage per quotient bit, most significant first
  for (genvar i = 0; i < CB; i++) begin : g_bit
    localparam int B = CB - 1 - i;
    logic [2:0][DW-1:0] trial;
    logic [2:0] take;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = (DW'(p_st[i][c]) << (B + 1)) + (DW'(s_st[i]) << (2 * B));
        take[c]  = (trial[c] <= DW'(r_st[i][c]));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zero_st[i+1] <= zero_st[i];
        neg_st[i+1]  <= neg_st[i];
        s_st[i+1]    <= s_st[i];
        for (int c = 0; c < 3; c++) begin
          if (take[c]) begin
            r_st[i+1][c] <= r_st[i][c] - RW'(trial[c]);
            p_st[i+1][c] <= p_st[i][c] + (PW'(s_st[i]) << B);
            q_st[i+1][c] <= q_st[i][c] | (CB'(1) << B);
          end else begin
            r_st[i+1][c] <= r_st[i][c];
            p_st[i+1][c] <= p_st[i][c];
            q_st[i+1][c] <= q_st[i][c];
          end
        end
      end
    end
  end

  // sign and saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!neg_st[CB][c]) begin
        clip[c] = q_st[CB][c][CB-1];
        res[c]  = clip[c] ? {1'b0, {(CB-1){1'b1}}} : q_st[CB][c];
      end else begin
        clip[c] = q_st[CB][c][CB-1] && (q_st[CB][c][CB-2:0] != '0);
        res[c]  = clip[c] ? {1'b1, {(CB-1){1'b0}}} : (~q_st[CB][c] + CB'(1));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[CB];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x      <= zero_st[CB] ? '0 : res[0];
      out_y      <= zero_st[CB] ? '0 : res[1];
      out_z      <= zero_st[CB] ? '0 : res[2];
      zero_input <= zero_st[CB];
      clipped    <= !zero_st[CB] && (clip != 3'b000);
    end
  end
endmodule

[design/vector_normalize_scale.sv]
// top level of the vector normalize and scale block
// instantiates vns_front, vns_queue and vns_back; uses vns_pkg
//
// Usage: an input transfer (in_valid && in_ready) carries in_x, in_y, in_z
// and target_length, signed Q16.16. Each yields one output transfer
// (out_valid && out_ready) with out_x, out_y, out_z = v * T / |v|,
// truncated toward zero and saturated, plus zero_input and clipped.
// Throughput: one vector per cycle while the receiver does not stall. Path: 4 front
// stages, the queue, 1 back entry stage, 32 quotient-bit stages, then the
// output register.
// The quotient search takes one bit per stage, which sets the depth.
// A two-entry queue separates the front pipeline from the back pipeline.
// When the receiver stalls the back pipeline holds, the queue fills, then
// the front holds and in_ready drops. Reset (rst, synchronous) empties all
// stages and the queue; no clearing pass is needed.
`include "assert_macros.svh"
module vector_normalize_scale import vns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CB-1:0] in_x,
  input  logic [CB-1:0] in_y,
  input  logic [CB-1:0] in_z,
  input  logic [CB-1:0] target_length,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CB-1:0] out_x,
  output logic [CB-1:0] out_y,
  output logic [CB-1:0] out_z,
  output logic          zero_input,
  output logic          clipped
);
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_data, pop_data;

  vns_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_x, .in_y, .in_z, .target_length,
    .push_valid, .push_ready, .push_data
  );

  vns_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  vns_back u_back (
    .clk, .rst, .pop_valid, .pop_ready, .pop_data,
    .out_valid, .out_ready, .out_x, .out_y, .out_z, .zero_input, .clipped
  );

  // zero vector never reports saturation and gives zero components
  `VNS_ASSERT_IMP(a_zero_noclip, clk, rst, out_valid && zero_input, !clipped)
  `VNS_ASSERT_IMP(a_zero_out, clk, rst, out_valid && zero_input,
                  out_x == '0 && out_y == '0 && out_z == '0)
  // a stalled result is held by the output register
  `VNS_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(out_x) && $stable(clipped))
endmodule

[tb/vector_normalize_scale_test.sv]
// testbench for vector_normalize_scale: random and directed vectors checked
// against an exact integer model of v * T / |v|; uses vns_pkg and the design
module vector_normalize_scale_test;
  import vns_pkg::*;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic          zero;
    logic          clip;
  } scaled_vec_t;

  // predicts each scaled vector and holds the pending ones in order
  class normalize_scoreboard;
    scaled_vec_t pending_q[$];
    int          errors = 0;
    bit          clip_seen;

    function logic [32:0] magnitude(logic [CB-1:0] v);
      return v[CB-1] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // trunc(v * t / sqrt(s)) by a bitwise search on q * q * s <= (v * t)^2
    function logic [CB-1:0] scale_component(logic [CB-1:0] v, logic [32:0] mag_t,
                                            bit neg_t, logic [191:0] s);
      logic [191:0] prod;
      logic [191:0] n;
      logic [191:0] c;
      logic [191:0] lhs;
      logic [63:0]  q;
      logic [63:0]  cand;
      bit           neg;
      neg = v[CB-1] != neg_t;
      prod = magnitude(v);
      prod = prod * mag_t;
      n = prod * prod;
      q = 0;
      for (int b = CB - 1; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        c = cand;
        lhs = c * c * s;
        if (lhs <= n) q = cand;
      end
      if (!neg) begin
        if (q > 64'h7fff_ffff) begin
          q = 64'h7fff_ffff;
          clip_seen = 1;
        end
        return q[CB-1:0];
      end
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        clip_seen = 1;
      end
      return (~q[CB-1:0]) + 1'b1;
    endfunction

    function void note_input(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                             logic [CB-1:0] t);
      scaled_vec_t  e;
      logic [191:0] mx;
      logic [191:0] my;
      logic [191:0] mz;
      logic [191:0] s;
      mx = magnitude(x);
      my = magnitude(y);
      mz = magnitude(z);
      s = mx * mx + my * my + mz * mz;
      clip_seen = 0;
      if (s == 0) begin
        e.x = '0;
        e.y = '0;
        e.z = '0;
        e.zero = 1;
        e.clip = 0;
      end else begin
        e.x = scale_component(x, magnitude(t), t[CB-1], s);
        e.y = scale_component(y, magnitude(t), t[CB-1], s);
        e.z = scale_component(z, magnitude(t), t[CB-1], s);
        e.zero = 0;
        e.clip = clip_seen;
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                               logic zero, logic clip);
      scaled_vec_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with no vector outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (x !== e.x) begin
        $error("out_x expected %0d got %0d", $signed(e.x), $signed(x));
        errors++;
      end
      if (y !== e.y) begin
        $error("out_y expected %0d got %0d", $signed(e.y), $signed(y));
        errors++;
      end
      if (z !== e.z) begin
        $error("out_z expected %0d got %0d", $signed(e.z), $signed(z));
        errors++;
      end
      if (zero !== e.zero) begin
        $error("zero_input expected %0b got %0b", e.zero, zero);
        errors++;
      end
      if (clip !== e.clip) begin
        $error("clipped expected %0b got %0b", e.clip, clip);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 3000;

  logic          clk = 0;
  logic          rst = 1;
  logic          in_valid = 0;
  logic          in_ready;
  logic [CB-1:0] in_x = '0;
  logic [CB-1:0] in_y = '0;
  logic [CB-1:0] in_z = '0;
  logic [CB-1:0] target_length = '0;
  logic          out_valid;
  logic          out_ready = 0;
  logic [CB-1:0] out_x;
  logic [CB-1:0] out_y;
  logic [CB-1:0] out_z;
  logic          zero_input;
  logic          clipped;

  normalize_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  vector_normalize_scale dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .target_length(target_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .zero_input(zero_input), .clipped(clipped)
  );

  always #6 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_x, in_y, in_z, target_length);
      if (out_valid && out_ready) sb.check_result(out_x, out_y, out_z, zero_input, clipped);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** vector_normalize_scale: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_vector(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                             logic [CB-1:0] t);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    target_length <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic logic [CB-1:0] random_component();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 20))) - (1 << 19);
    endcase
  endfunction

  function automatic logic [CB-1:0] random_target();
    case ($urandom_range(4))
      0: return 32'h0001_0000;
      1: return $urandom;
      2: return $signed($urandom_range(1 << 24)) - (1 << 23);
      3: return $urandom_range(3) == 0 ? 32'h0 : 32'hffff_0000;
      default: return 32'($signed($urandom_range(200))) - 100;
    endcase
  endfunction

  task automatic run_random(int count);
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    for (int i = 0; i < count; i++) begin
      x = random_component();
      y = random_component();
      z = random_component();
      // a few zero vectors and single-axis vectors
      if ($urandom_range(29) == 0) begin
        x = 0;
        y = 0;
        z = 0;
      end else if ($urandom_range(9) == 0) begin
        y = 0;
        z = 0;
      end
      send_vector(x, y, z, random_target());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero vector, extremes, unit target, zero and negative targets
    send_vector(0, 0, 0, 32'h0001_0000);
    send_vector(0, 0, 0, 32'h8000_0000);
    send_vector(32'h0001_0000, 0, 0, 32'h0001_0000);
    send_vector(0, 32'hffff_0000, 0, 32'h0001_0000);
    send_vector(0, 0, 32'h0003_0000, 32'h0005_0000);
    send_vector(32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
    send_vector(32'h8000_0000, 0, 0, 32'h8000_0000);
    send_vector(32'h8000_0000, 0, 0, 32'h7fff_ffff);
    send_vector(32'h7fff_ffff, 0, 0, 32'h8000_0000);
    send_vector(1, 0, 0, 32'h7fff_ffff);
    send_vector(1, 0, 0, 32'h8000_0000);
    send_vector(1, 1, 1, 32'h7fff_ffff);
    send_vector(32'hffff_ffff, 1, 0, 32'h8000_0000);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0);
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffe_0000);
    send_vector(32'h1234_5678, 32'hedcb_a988, 32'h0f0f_0f0f, 32'h0001_0000);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);

    // no idling, with one long receiver hold-off to fill the pipeline
    hold_cycles = 200;
    run_random(310);
    send_idle_pct = 52;
    run_random(310);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    run_random(310);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random(310);

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** vector_normalize_scale: PASSED **");
    end else begin
      $display("** vector_normalize_scale: FAILED **");
    end
    $finish;
  end
endmodule
